FILE: src/gpio_ei_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_ei_pkg
// Opcodes, register indexes and lane structs shared by the GPIO port blocks.
// ----------------------------------------------------------------------------
package gpio_ei_pkg;

  // Word opcodes.
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Register map.
  localparam logic [3:0] REG_MODE  = 4'd0;
  localparam logic [3:0] REG_OTYPE = 4'd1;
  localparam logic [3:0] REG_SPEED = 4'd2;
  localparam logic [3:0] REG_PULL  = 4'd3;
  localparam logic [3:0] REG_IDR   = 4'd4;
  localparam logic [3:0] REG_ODR   = 4'd5;
  localparam logic [3:0] REG_AFL   = 4'd6;
  localparam logic [3:0] REG_AFH   = 4'd7;
  localparam logic [3:0] REG_RISE  = 4'd8;
  localparam logic [3:0] REG_FALL  = 4'd9;
  localparam logic [3:0] REG_MASK  = 4'd10;
  localparam logic [3:0] REG_PEND  = 4'd11;

  // Pins per alternate-function register.
  localparam int unsigned AF_PINS = 8;

  // Command broadcast to all lanes and to the merge stage.
  typedef struct packed {
    logic       fire;
    logic [1:0] opcode;
    logic [3:0] reg_index;
  } lane_cmd_t;

  // Per-pin state as seen by the merge stage.
  typedef struct packed {
    logic [1:0] mode;
    logic       otype;
    logic [1:0] speed;
    logic [1:0] pull;
    logic       idr;
    logic       odr;
    logic [3:0] af;
    logic       rise;
    logic       fall;
    logic       mask;
    logic       pend;
    logic       odr_nx;
    logic       irq_nx;
  } lane_stat_t;

endpackage
`default_nettype wire

FILE: src/gpio_ei_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_ei_in_if
// Request channel: register reads, register writes and pin samples.
// ----------------------------------------------------------------------------
interface gpio_ei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  reg_index;
  logic [31:0] write_data;
  logic [15:0] pin_levels;

  modport source (output valid, output opcode, output reg_index, output write_data,
                  output pin_levels, input ready);
  modport sink   (input valid, input opcode, input reg_index, input write_data,
                  input pin_levels, output ready);
endinterface
`default_nettype wire

FILE: src/gpio_ei_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_ei_out_if
// Response channel: read data, pin drive and interrupt line after each word.
// ----------------------------------------------------------------------------
interface gpio_ei_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [15:0] pin_drive;
  logic        irq;

  modport source (output valid, output read_data, output pin_drive, output irq,
                  input ready);
  modport sink   (input valid, input read_data, input pin_drive, input irq,
                  output ready);
endinterface
`default_nettype wire

FILE: src/gpio_ei_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_ei_lane
// Register bits and edge detector of one pin.
// ----------------------------------------------------------------------------
module gpio_ei_lane import gpio_ei_pkg::*; #(
  parameter int unsigned PIN_ID = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lane_cmd_t   cmd_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic        pin_level_i,
  output lane_stat_t       stat_o
);

  localparam int unsigned AF_LSB  = (PIN_ID % AF_PINS) * 4;
  localparam bit          AF_HIGH = (PIN_ID >= AF_PINS);

  logic [1:0] mode_q, mode_d;
  logic       otype_q, otype_d;
  logic [1:0] speed_q, speed_d;
  logic [1:0] pull_q, pull_d;
  logic       idr_q, idr_d;
  logic       odr_q, odr_d;
  logic [3:0] af_q, af_d;
  logic       rise_q, rise_d;
  logic       fall_q, fall_d;
  logic       mask_q, mask_d;
  logic       pend_q, pend_d;

  always_comb begin
    mode_d  = mode_q;
    otype_d = otype_q;
    speed_d = speed_q;
    pull_d  = pull_q;
    idr_d   = idr_q;
    odr_d   = odr_q;
    af_d    = af_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    mask_d  = mask_q;
    pend_d  = pend_q;
    if (cmd_i.fire) begin
      case (cmd_i.opcode)
        OP_WRITE: begin
          case (cmd_i.reg_index)
            REG_MODE:  mode_d  = write_data_i[2*PIN_ID +: 2];
            REG_OTYPE: otype_d = write_data_i[PIN_ID];
            REG_SPEED: speed_d = write_data_i[2*PIN_ID +: 2];
            REG_PULL:  pull_d  = write_data_i[2*PIN_ID +: 2];
            REG_ODR:   odr_d   = write_data_i[PIN_ID];
            REG_AFL: begin
              if (!AF_HIGH) af_d = write_data_i[AF_LSB +: 4];
            end
            REG_AFH: begin
              if (AF_HIGH) af_d = write_data_i[AF_LSB +: 4];
            end
            REG_RISE:  rise_d  = write_data_i[PIN_ID];
            REG_FALL:  fall_d  = write_data_i[PIN_ID];
            REG_MASK:  mask_d  = write_data_i[PIN_ID];
            // Pending is write-one-to-clear.
            REG_PEND:  pend_d  = pend_q & ~write_data_i[PIN_ID];
            default: ;
          endcase
        end
        OP_SAMPLE: begin
          idr_d  = pin_level_i;
          pend_d = pend_q | (pin_level_i & ~idr_q & rise_q)
                          | (idr_q & ~pin_level_i & fall_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      otype_q <= 1'b0;
      speed_q <= '0;
      pull_q  <= '0;
      idr_q   <= 1'b0;
      odr_q   <= 1'b0;
      af_q    <= '0;
      rise_q  <= 1'b0;
      fall_q  <= 1'b0;
      mask_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      otype_q <= otype_d;
      speed_q <= speed_d;
      pull_q  <= pull_d;
      idr_q   <= idr_d;
      odr_q   <= odr_d;
      af_q    <= af_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      mask_q  <= mask_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    stat_o.mode   = mode_q;
    stat_o.otype  = otype_q;
    stat_o.speed  = speed_q;
    stat_o.pull   = pull_q;
    stat_o.idr    = idr_q;
    stat_o.odr    = odr_q;
    stat_o.af     = af_q;
    stat_o.rise   = rise_q;
    stat_o.fall   = fall_q;
    stat_o.mask   = mask_q;
    stat_o.pend   = pend_q;
    stat_o.odr_nx = odr_d;
    stat_o.irq_nx = pend_d & mask_d;
  end

  // A selected rising edge always leaves the pending bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fire && cmd_i.opcode == OP_SAMPLE && pin_level_i && !idr_q && rise_q)
      |=> pend_q)
    else $error("rising edge did not set pending");

  // Pending only rises on a sample word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pend_q && !(cmd_i.fire && cmd_i.opcode == OP_SAMPLE)) |=> !pend_q)
    else $error("pending set without a pin sample");

  // Writing a one to this pin's pending bit clears it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fire && cmd_i.opcode == OP_WRITE && cmd_i.reg_index == REG_PEND
      && write_data_i[PIN_ID]) |=> !pend_q)
    else $error("pending not cleared by a one");

endmodule
`default_nettype wire

FILE: src/gpio_ei_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_ei_merge
// Gathers the lane bits into register words and registers the response.
// ----------------------------------------------------------------------------
module gpio_ei_merge import gpio_ei_pkg::*; #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  wire logic                        clk_i,
  input  wire lane_cmd_t                   cmd_i,
  input  wire lane_stat_t [PIN_COUNT-1:0]  lanes_i,
  output logic [31:0]                      read_data_o,
  output logic [15:0]                      pin_drive_o,
  output logic                             irq_o
);

  logic [31:0] mode_w, speed_w, pull_w, afl_w, afh_w;
  logic [15:0] otype_w, idr_w, odr_w, rise_w, fall_w, mask_w, pend_w, odr_nx_w;
  logic        irq_nx;
  logic [31:0] rd_d;
  logic [31:0] read_data_q;
  logic [15:0] pin_drive_q;
  logic        irq_q;

  always_comb begin
    mode_w   = '0;
    speed_w  = '0;
    pull_w   = '0;
    afl_w    = '0;
    afh_w    = '0;
    otype_w  = '0;
    idr_w    = '0;
    odr_w    = '0;
    rise_w   = '0;
    fall_w   = '0;
    mask_w   = '0;
    pend_w   = '0;
    odr_nx_w = '0;
    irq_nx   = 1'b0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      mode_w[2*p +: 2]  = lanes_i[p].mode;
      speed_w[2*p +: 2] = lanes_i[p].speed;
      pull_w[2*p +: 2]  = lanes_i[p].pull;
      if (p < AF_PINS) begin
        afl_w[4*(p % AF_PINS) +: 4] = lanes_i[p].af;
      end else begin
        afh_w[4*(p % AF_PINS) +: 4] = lanes_i[p].af;
      end
      otype_w[p]  = lanes_i[p].otype;
      idr_w[p]    = lanes_i[p].idr;
      odr_w[p]    = lanes_i[p].odr;
      rise_w[p]   = lanes_i[p].rise;
      fall_w[p]   = lanes_i[p].fall;
      mask_w[p]   = lanes_i[p].mask;
      pend_w[p]   = lanes_i[p].pend;
      odr_nx_w[p] = lanes_i[p].odr_nx;
      irq_nx      = irq_nx | lanes_i[p].irq_nx;
    end
  end

  always_comb begin
    rd_d = '0;
    if (cmd_i.opcode == OP_READ) begin
      case (cmd_i.reg_index)
        REG_MODE:  rd_d = mode_w;
        REG_OTYPE: rd_d = {16'd0, otype_w};
        REG_SPEED: rd_d = speed_w;
        REG_PULL:  rd_d = pull_w;
        REG_IDR:   rd_d = {16'd0, idr_w};
        REG_ODR:   rd_d = {16'd0, odr_w};
        REG_AFL:   rd_d = afl_w;
        REG_AFH:   rd_d = afh_w;
        REG_RISE:  rd_d = {16'd0, rise_w};
        REG_FALL:  rd_d = {16'd0, fall_w};
        REG_MASK:  rd_d = {16'd0, mask_w};
        REG_PEND:  rd_d = {16'd0, pend_w};
        default:   rd_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      read_data_q <= rd_d;
      pin_drive_q <= odr_nx_w;
      irq_q       <= irq_nx;
    end
  end

  assign read_data_o = read_data_q;
  assign pin_drive_o = pin_drive_q;
  assign irq_o       = irq_q;

endmodule
`default_nettype wire

FILE: src/gpio_port_with_edge_interrupts_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_port_with_edge_interrupts_core
// GPIO port with per-pin edge interrupt logic, one lane per pin.
// ----------------------------------------------------------------------------
//  Channel  Dir  Modport  Word contents
//  req_i    in   sink     opcode, reg_index, write_data, pin_levels
//  rsp_o    out  source   read_data, pin_drive, irq
//
// Every accepted word yields one response word in the next cycle.
// A new word is taken every cycle; the response register is the only stage,
// so req_i.ready drops only while a response is held by rsp_o.ready low.
// Reset clears all lane registers and the response valid flag; the response data registers are not reset.
// Register updates take effect at the accepting edge.
module gpio_port_with_edge_interrupts_core import gpio_ei_pkg::*; #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  gpio_ei_in_if.sink     req_i,
  gpio_ei_out_if.source  rsp_o
);

  lane_cmd_t                   cmd;
  lane_stat_t [PIN_COUNT-1:0]  lanes;
  logic                        out_valid_q, out_valid_d;
  logic                        in_ready;

  assign in_ready = !out_valid_q || rsp_o.ready;
  assign req_i.ready = in_ready;

  always_comb begin
    cmd.fire      = req_i.valid && in_ready;
    cmd.opcode    = req_i.opcode;
    cmd.reg_index = req_i.reg_index;
  end

  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_lane
    gpio_ei_lane #(
      .PIN_ID (p)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .write_data_i (req_i.write_data),
      .pin_level_i  (req_i.pin_levels[p]),
      .stat_o       (lanes[p])
    );
  end

  gpio_ei_merge #(
    .PIN_COUNT (PIN_COUNT)
  ) u_merge (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .lanes_i     (lanes),
    .read_data_o (rsp_o.read_data),
    .pin_drive_o (rsp_o.pin_drive),
    .irq_o       (rsp_o.irq)
  );

  assign out_valid_d = cmd.fire || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid = out_valid_q;

  // A held response must block the request side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted while response stalled");

  // Every accepted word shows up as a response in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |=> rsp_o.valid)
    else $error("accepted word produced no response");

  // Only reads return data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fire && cmd.opcode != OP_READ) |=> (rsp_o.read_data == 32'd0))
    else $error("non-read word returned data");

endmodule
`default_nettype wire
